>>> design/ilt_pkg.sv
// Shared types and constants of the indexed list table engine.
// No dependencies; every other design file imports this package.
package ilt_pkg;

    // Store geometry
    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 4;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH        = 4'd0,
        REQ_POP         = 4'd1,
        REQ_INSERT      = 4'd2,
        REQ_REMOVE      = 4'd3,
        REQ_SWAP_REMOVE = 4'd4,
        REQ_SWAP        = 4'd5,
        REQ_GET         = 4'd6,
        REQ_FIRST       = 4'd7,
        REQ_LAST        = 4'd8,
        REQ_CLEAR       = 4'd9
    } t_req;

    // Status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Memory access request from the sequencer to the store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

endpackage

>>> design/ilt_store.sv
// Element store: one write port, one read port, registered read data.
// Depends on ilt_pkg for geometry and the t_mem_req access struct.
module ilt_store (
    input  logic                      i_clk,
    input  ilt_pkg::t_mem_req         i_req,
    output logic [ilt_pkg::DATA_W-1:0] o_rd_data
);
    import ilt_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ilt_ctrl.sv
// Request sequencer: decodes a request, drives store reads and writes,
// runs the shift loops of insert and remove, and registers the result.
// Depends on ilt_pkg.
module ilt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ilt_pkg::REQ_W-1:0]  i_req_type,
    input  logic [ilt_pkg::CNT_W-1:0]  i_index_a,
    input  logic [ilt_pkg::ADDR_W-1:0] i_index_b,
    input  logic [ilt_pkg::DATA_W-1:0] i_value,
    output ilt_pkg::t_mem_req          o_mem,
    input  logic [ilt_pkg::DATA_W-1:0] i_rd_data,
    output logic                       o_strobe,
    output logic [ilt_pkg::DATA_W-1:0] o_read_data,
    output logic [ilt_pkg::ST_W-1:0]   o_status,
    output logic [ilt_pkg::CNT_W-1:0]  o_count
);
    import ilt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_SWAP_RD = 7'b0000100,
        S_SWAP_WR = 7'b0001000,
        S_SHIFT_DN = 7'b0010000,
        S_SHIFT_UP = 7'b0100000,
        S_PUT     = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [REQ_W-1:0]  r_req;
    logic [CNT_W-1:0]  r_ia;
    logic [ADDR_W-1:0] r_ib;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_strobe, n_strobe;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    t_status           r_status, n_status;

    logic              accept;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  ia_p1;
    logic [CNT_W-1:0]  ptr_ext;
    logic [CNT_W-1:0]  ptr_p2;
    logic [CNT_W-1:0]  ptr_m2;
    logic              bad_a;
    logic              bad_b;
    logic              empty;
    logic              full;

    assign accept  = i_start && (r_state == S_IDLE);
    assign cnt_m1  = r_count - CNT_ONE;
    assign ia_p1   = r_ia + CNT_ONE;
    assign ptr_ext = {1'b0, r_ptr};
    assign ptr_p2  = ptr_ext + CNT_TWO;
    assign ptr_m2  = ptr_ext - CNT_TWO;
    assign bad_a   = (r_ia >= r_count);
    assign bad_b   = ({1'b0, r_ib} >= r_count);
    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_FULL);

    // Sequencer next state, store accesses and result
    always_comb begin
        logic [CNT_W-1:0] acc_a_p1;
        acc_a_p1    = i_index_a + CNT_ONE;
        n_state     = r_state;
        n_tmp       = r_tmp;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_read_data = r_read_data;
        n_status    = r_status;
        o_mem       = '0;

        case (r_state)
            S_IDLE: begin
                // first read goes out with the transfer
                if (accept) begin
                    n_state    = S_EXEC;
                    o_mem.rd_en = 1'b1;
                    case (i_req_type)
                        REQ_GET, REQ_SWAP: o_mem.rd_addr = i_index_a[ADDR_W-1:0];
                        REQ_LAST, REQ_SWAP_REMOVE, REQ_INSERT:
                            o_mem.rd_addr = cnt_m1[ADDR_W-1:0];
                        REQ_REMOVE: o_mem.rd_addr = acc_a_p1[ADDR_W-1:0];
                        default:    o_mem.rd_addr = '0;
                    endcase
                end
            end
            S_EXEC: begin
                // most requests finish here
                n_strobe    = 1'b1;
                n_state     = S_IDLE;
                n_status    = ST_OK;
                n_read_data = '0;
                case (r_req)
                    REQ_PUSH: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_count[ADDR_W-1:0];
                            o_mem.wr_data = r_val;
                            n_count       = r_count + CNT_ONE;
                        end
                    end
                    REQ_POP: begin
                        if (empty) begin
                            n_status = ST_BAD;
                        end else begin
                            n_count = cnt_m1;
                        end
                    end
                    REQ_INSERT: begin
                        if (r_ia > r_count) begin
                            n_status = ST_BAD;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else if (r_ia == r_count) begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_ia[ADDR_W-1:0];
                            o_mem.wr_data = r_val;
                            n_count       = r_count + CNT_ONE;
                        end else begin
                            n_strobe = 1'b0;
                            n_ptr    = r_count[ADDR_W-1:0];
                            n_state  = S_SHIFT_UP;
                        end
                    end
                    REQ_REMOVE: begin
                        if (bad_a) begin
                            n_status = ST_BAD;
                        end else if (ia_p1 == r_count) begin
                            n_count = cnt_m1;
                        end else begin
                            n_strobe = 1'b0;
                            n_ptr    = r_ia[ADDR_W-1:0];
                            n_state  = S_SHIFT_DN;
                        end
                    end
                    REQ_SWAP_REMOVE: begin
                        if (bad_a) begin
                            n_status = ST_BAD;
                        end else begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_ia[ADDR_W-1:0];
                            o_mem.wr_data = i_rd_data;
                            n_count       = cnt_m1;
                        end
                    end
                    REQ_SWAP: begin
                        if (bad_a || bad_b) begin
                            n_status = ST_BAD;
                        end else begin
                            n_strobe      = 1'b0;
                            n_tmp         = i_rd_data;
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = r_ib;
                            n_state       = S_SWAP_RD;
                        end
                    end
                    REQ_GET: begin
                        if (bad_a) begin
                            n_status = ST_BAD;
                        end else begin
                            n_read_data = i_rd_data;
                        end
                    end
                    REQ_FIRST, REQ_LAST: begin
                        if (empty) begin
                            n_status = ST_BAD;
                        end else begin
                            n_read_data = i_rd_data;
                        end
                    end
                    REQ_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            S_SWAP_RD: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ia[ADDR_W-1:0];
                o_mem.wr_data = i_rd_data;
                n_state       = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ib;
                o_mem.wr_data = r_tmp;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
            end
            S_SHIFT_DN: begin
                // entry ptr+1 moves to ptr, next source read in flight
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ptr;
                o_mem.wr_data = i_rd_data;
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ptr_p2[ADDR_W-1:0];
                n_ptr         = r_ptr + ADDR_W'(1);
                if (ptr_p2 == r_count) begin
                    n_count  = cnt_m1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT_UP: begin
                // entry ptr-1 moves to ptr
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ptr;
                o_mem.wr_data = i_rd_data;
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ptr_m2[ADDR_W-1:0];
                n_ptr         = r_ptr - ADDR_W'(1);
                if (ptr_ext == ia_p1) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ia[ADDR_W-1:0];
                o_mem.wr_data = r_val;
                n_count       = r_count + CNT_ONE;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Request capture and working data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_ia  <= i_index_a;
            r_ib  <= i_index_b;
            r_val <= i_value;
        end
        r_tmp       <= n_tmp;
        r_ptr       <= n_ptr;
        r_read_data <= n_read_data;
        r_status    <= n_status;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

>>> design/indexed_list_table_engine.sv
// Top level of the indexed list table engine: sequencer plus element store.
// Depends on ilt_pkg, ilt_ctrl and ilt_store.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+--------------------------------------------
//   request   | i_start, o_busy       | i_req_type, i_index_a, i_index_b, i_value
//   result    | o_strobe (one cycle)  | o_read_data, o_status, o_count, o_is_empty
//
// A transfer happens when i_start is high and o_busy is low. Push, pop, get,
// first, last, clear, swap_remove, an insert at the end of the list and failed
// requests finish in the execute state; swap then reads the second entry and
// writes both entries back; an insert below the count and a remove shift the
// entries in between, one store entry moved per cycle on the single write port.
// i_rst_n is synchronous: it empties the list; the store contents are not
// cleared. The receiver cannot stall; o_busy holds requests.
module indexed_list_table_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ilt_pkg::REQ_W-1:0]  i_req_type,
    input  logic [ilt_pkg::CNT_W-1:0]  i_index_a,
    input  logic [ilt_pkg::ADDR_W-1:0] i_index_b,
    input  logic [ilt_pkg::DATA_W-1:0] i_value,
    output logic                       o_strobe,
    output logic [ilt_pkg::DATA_W-1:0] o_read_data,
    output logic [ilt_pkg::ST_W-1:0]   o_status,
    output logic [ilt_pkg::CNT_W-1:0]  o_count,
    output logic                       o_is_empty
);
    import ilt_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] rd_data;

    // Sequencer
    ilt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_type  (i_req_type),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_value     (i_value),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_strobe    (o_strobe),
        .o_read_data (o_read_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    // Element store
    ilt_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_is_empty = (o_count == '0);

endmodule

>>> design/ilt_checker.sv
// Port-level checks of the indexed list table engine, bound to the top level.
// Depends on ilt_pkg and indexed_list_table_engine.
module ilt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic                       o_strobe,
    input logic [ilt_pkg::ST_W-1:0]   o_status,
    input logic [ilt_pkg::CNT_W-1:0]  o_count
);
    import ilt_pkg::*;

    // a transfer always makes the engine busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("engine not busy after a request transfer");

    // a result only closes a request in progress, and frees the engine
    a_strobe_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(o_busy) && !o_busy))
        else $error("result strobe without a request in progress");

    // the count only moves together with a result
    a_count_moves_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_count) |-> o_strobe)
        else $error("count changed without a result");

    // a full status means the list really is at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> (o_count == CNT_FULL))
        else $error("full status while the list has room");

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count <= CNT_FULL)
        else $error("count beyond capacity");

endmodule

bind indexed_list_table_engine ilt_checker u_ilt_checker (.*);
